// ===== design/open_address_hash_table_macros.svh =====
// assertion macros for the open-address hash table checker
// expects clk and rst in the scope of each use
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OAHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/oaht_pkg.sv =====
// shared types and constants of the open-address hash table
// no dependencies
package oaht_pkg;

  localparam int KEY_W      = 31;
  localparam int TSIZE_W    = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_HOME  = 3'd0,
    ST_COLL  = 3'd1,
    ST_FULL  = 3'd2,
    ST_FOUND = 3'd3,
    ST_MISS  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE = 4'd0,
    CFG_PROBE_MODE = 4'd1
  } cfg_idx_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic MODE_LINEAR    = 1'b0;
  localparam logic MODE_QUADRATIC = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic start;
    logic div_step;
    logic read;
    logic advance;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic probe_done;
  } dp_stat_t;

endpackage

// ===== design/open_address_hash_table.sv =====
// top level of the open-address hash table: ports, configuration registers
// depends on oaht_pkg, oaht_ctrl, oaht_dp (and oaht_ram below it)
//
// Open-addressing hash table of 31-bit keys, one item at a time. Each input
// transfer is an insert (kind 0) or a search (kind 1); each gives exactly one
// result transfer with status, slot, probe count and the running collision
// total. The home slot is key mod table_size, found by a restoring divider
// that retires one key bit per cycle. Probing then walks the slot ram, one
// probe after another (registered read, then compare); an exhausted table
// reports the table size as its probe count but walks one step fewer.
// The next item is taken while a result still waits in the output register;
// the probe of that next item holds at its final compare until the output is
// taken. After reset a clearing pass writes every one of the DEPTH ram
// entries as empty, one per cycle, and inputs stall until it ends;
// configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while the block is idle.
module open_address_hash_table #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [oaht_pkg::KEY_W-1:0]        key,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [oaht_pkg::STATUS_W-1:0]     status,
  output logic [$clog2(DEPTH)-1:0]          slot,
  output logic [$clog2(DEPTH):0]            probes,
  output logic [oaht_pkg::COUNT_W-1:0]      collision_count,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oaht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [oaht_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [oaht_pkg::TSIZE_W-1:0] table_size;
  logic                         probe_mode;

  oaht_pkg::dp_cmd_t  cmd;
  oaht_pkg::dp_stat_t stat;

  // writes are never held off
  assign cfg_ready = 1'b1;

  // unknown indexes fall through and change nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= oaht_pkg::TSIZE_W'(1024);
      probe_mode <= oaht_pkg::MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        oaht_pkg::CFG_TABLE_SIZE: begin
          table_size <= cfg_data[oaht_pkg::TSIZE_W-1:0];
        end
        oaht_pkg::CFG_PROBE_MODE: begin
          probe_mode <= cfg_data[0];
        end
        default: begin
          table_size <= table_size;
        end
      endcase
    end
  end

  // sequencer: clearing pass, division, read/compare probe loop
  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // divider, probe address generator, slot ram and result registers
  oaht_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .table_size     (table_size),
    .probe_mode     (probe_mode),
    .kind           (kind),
    .key            (key),
    .status         (status),
    .slot           (slot),
    .probes         (probes),
    .collision_count(collision_count)
  );

endmodule

// ===== design/oaht_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/oaht_ctrl.sv =====
// sequencing state machine of the open-address hash table
// depends on oaht_pkg
module oaht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output oaht_pkg::dp_cmd_t  cmd,
  input  oaht_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.probe_done) begin
          // hold the final compare until the output register can take a result
          if (out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/oaht_dp.sv =====
// datapath: home-slot divider, probe address generator, slot ram, results
// depends on oaht_pkg and oaht_ram
module oaht_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  oaht_pkg::dp_cmd_t                 cmd,
  output oaht_pkg::dp_stat_t                stat,
  input  logic [oaht_pkg::TSIZE_W-1:0]      table_size,
  input  logic                              probe_mode,
  input  logic                              kind,
  input  logic [oaht_pkg::KEY_W-1:0]        key,
  output logic [oaht_pkg::STATUS_W-1:0]     status,
  output logic [$clog2(DEPTH)-1:0]          slot,
  output logic [$clog2(DEPTH):0]            probes,
  output logic [oaht_pkg::COUNT_W-1:0]      collision_count
);

  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SIZE_W    = ADDR_W + 1;
  localparam int DIV_CNT_W = $clog2(oaht_pkg::KEY_W);
  localparam int RAM_W     = oaht_pkg::KEY_W + 1;

  // item registers
  logic                        kind_r;
  logic                        mode_r;
  logic [oaht_pkg::KEY_W-1:0]  key_r;
  logic [oaht_pkg::KEY_W-1:0]  key_sh;
  logic [SIZE_W-1:0]           size_r;
  logic [DIV_CNT_W-1:0]        div_cnt;
  logic [ADDR_W-1:0]           cur;      // remainder during division, then probe slot
  logic [ADDR_W-1:0]           delta;    // (2c+1) mod size for quadratic mode
  logic [SIZE_W-1:0]           c;
  logic [ADDR_W-1:0]           clr_cnt;

  // result registers
  oaht_pkg::status_t           status_r;
  logic [ADDR_W-1:0]           slot_r;
  logic [SIZE_W-1:0]           probes_r;
  logic [oaht_pkg::COUNT_W-1:0] coll_total;

  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] div_t;
  logic [SIZE_W-1:0] step;
  logic [SIZE_W-1:0] sum;
  logic [SIZE_W-1:0] dsum;
  logic [SIZE_W-1:0] c_inc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  logic used;
  logic key_eq;
  logic is_search;
  logic empty_hit;
  logic early;
  logic last;
  logic ins_empty;

  // size zero acts as one slot, above the depth saturates
  always_comb begin
    if (table_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (int'(table_size) > DEPTH) begin
      eff_size = SIZE_W'(DEPTH);
    end else begin
      eff_size = SIZE_W'(table_size);
    end
  end

  assign div_t = {cur, key_sh[oaht_pkg::KEY_W-1]};
  assign step  = (mode_r == oaht_pkg::MODE_QUADRATIC) ? SIZE_W'(delta) : SIZE_W'(1);
  assign sum   = SIZE_W'(cur) + step;
  assign dsum  = SIZE_W'(delta) + SIZE_W'(2);
  assign c_inc = c + SIZE_W'(1);

  assign used      = ram_rdata[oaht_pkg::KEY_W];
  assign key_eq    = (ram_rdata[oaht_pkg::KEY_W-1:0] == key_r);
  assign is_search = (kind_r == oaht_pkg::KIND_SEARCH);
  assign empty_hit = !used;
  assign early     = empty_hit || (is_search && key_eq);
  assign last      = (c_inc == size_r);
  assign ins_empty = !is_search && empty_hit;

  assign stat.clear_last = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign stat.div_last   = (div_cnt == DIV_CNT_W'(oaht_pkg::KEY_W - 1));
  assign stat.probe_done = early || last;

  assign ram_we    = cmd.clear || (cmd.finish && ins_empty);
  assign ram_waddr = cmd.clear ? clr_cnt : cur;
  assign ram_wdata = cmd.clear ? '0 : {1'b1, key_r};

  oaht_ram #(
    .WIDTH(RAM_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.read),
    .raddr(cur),
    .rdata(ram_rdata)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      coll_total <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.finish && ins_empty && (c != '0)) begin
        coll_total <= coll_total + oaht_pkg::COUNT_W'(1);
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r  <= kind;
      key_r   <= key;
      key_sh  <= key;
      size_r  <= eff_size;
      mode_r  <= probe_mode;
      div_cnt <= '0;
      cur     <= '0;
      delta   <= ADDR_W'(1);
      c       <= '0;
    end
    if (cmd.div_step) begin
      key_sh  <= key_sh << 1;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (div_t >= size_r) begin
        cur <= ADDR_W'(div_t - size_r);
      end else begin
        cur <= ADDR_W'(div_t);
      end
    end
    if (cmd.advance) begin
      c <= c_inc;
      if (sum >= size_r) begin
        cur <= ADDR_W'(sum - size_r);
      end else begin
        cur <= ADDR_W'(sum);
      end
      if (dsum >= size_r) begin
        delta <= ADDR_W'(dsum - size_r);
      end else begin
        delta <= ADDR_W'(dsum);
      end
    end
    if (cmd.finish) begin
      probes_r <= early ? c : size_r;
      if (is_search) begin
        status_r <= key_eq && used ? oaht_pkg::ST_FOUND : oaht_pkg::ST_MISS;
        slot_r   <= key_eq && used ? cur : '0;
      end else if (empty_hit) begin
        status_r <= (c == '0) ? oaht_pkg::ST_HOME : oaht_pkg::ST_COLL;
        slot_r   <= cur;
      end else begin
        status_r <= oaht_pkg::ST_FULL;
        slot_r   <= '0;
      end
    end
  end

  assign status          = status_r;
  assign slot            = slot_r;
  assign probes          = probes_r;
  assign collision_count = coll_total;

endmodule

// ===== design/oaht_checker.sv =====
// port-level checks of the open-address hash table, bound to the top level
// depends on oaht_pkg and open_address_hash_table_macros.svh
`include "open_address_hash_table_macros.svh"

module oaht_checker #(
  parameter int DEPTH = 1024
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [oaht_pkg::STATUS_W-1:0]     status,
  input logic [$clog2(DEPTH)-1:0]          slot,
  input logic [$clog2(DEPTH):0]            probes,
  input logic [oaht_pkg::COUNT_W-1:0]      collision_count
);

  localparam int RES_W = oaht_pkg::STATUS_W + 2 * $clog2(DEPTH) + 1 + oaht_pkg::COUNT_W;

  logic             held;
  logic             in_take;
  logic             no_slot;
  logic             res_home;
  logic             res_coll;
  logic [RES_W-1:0] res_bits;

  assign held     = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign no_slot  = out_valid &&
                    (status == oaht_pkg::ST_FULL || status == oaht_pkg::ST_MISS);
  assign res_home = out_valid && (status == oaht_pkg::ST_HOME);
  assign res_coll = out_valid && (status == oaht_pkg::ST_COLL);
  assign res_bits = {status, slot, probes, collision_count};

  // a stalled result stays put
  `OAHT_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(res_bits), "stalled result changed")

  // one item at a time: an accepted item closes the input
  `OAHT_ASSERT_NEXT(a_one_item, in_take, in_stall, "input open right after a transfer")

  // full and not-found results report slot zero
  `OAHT_ASSERT_SAME(a_slot_zero, no_slot, slot == '0, "slot not zero on full or miss")

  // home inserts take no probe step, collided inserts at least one
  `OAHT_ASSERT_SAME(a_home_probes, res_home, probes == '0, "home insert with probe steps")
  `OAHT_ASSERT_SAME(a_coll_probes, res_coll, probes != '0, "collided insert without steps")

endmodule

bind open_address_hash_table oaht_checker #(.DEPTH(DEPTH)) u_checker (.*);

// ===== sim/open_address_hash_table_tb.sv =====
// self-checking testbench of the open-address hash table, inserts and searches
// depends on oaht_pkg and the open_address_hash_table top level only
// a directed table runs first, then random phases, then the table is filled
module open_address_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // package names used below
  localparam int KEY_W      = oaht_pkg::KEY_W;
  localparam int TSIZE_W    = oaht_pkg::TSIZE_W;
  localparam int CFG_IDX_W  = oaht_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = oaht_pkg::CFG_DATA_W;
  localparam int STATUS_W   = oaht_pkg::STATUS_W;
  localparam int COUNT_W    = oaht_pkg::COUNT_W;

  typedef oaht_pkg::status_t status_t;

  localparam status_t ST_HOME  = oaht_pkg::ST_HOME;
  localparam status_t ST_COLL  = oaht_pkg::ST_COLL;
  localparam status_t ST_FULL  = oaht_pkg::ST_FULL;
  localparam status_t ST_FOUND = oaht_pkg::ST_FOUND;
  localparam status_t ST_MISS  = oaht_pkg::ST_MISS;

  localparam logic KIND_INSERT    = oaht_pkg::KIND_INSERT;
  localparam logic KIND_SEARCH    = oaht_pkg::KIND_SEARCH;
  localparam logic MODE_LINEAR    = oaht_pkg::MODE_LINEAR;
  localparam logic MODE_QUADRATIC = oaht_pkg::MODE_QUADRATIC;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = oaht_pkg::CFG_TABLE_SIZE;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = oaht_pkg::CFG_PROBE_MODE;

  localparam int DEPTH   = 1024;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int PROBE_W = SLOT_W + 1;

  localparam int          RESET_CYCLES   = 5;
  localparam int          IDLE_PCT       = 34;
  localparam int          RANDOM_PHASES  = 10;
  localparam int          PHASE_ITEMS    = 100;
  localparam int          CALM_PHASE     = 3;
  localparam int          HOLD_AT        = 250;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          TAIL_CYCLES    = 100;
  localparam int          REPORT_LIMIT   = 10;
  localparam longint      CYCLE_LIMIT    = 5_000_000;
  localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};
  // first register index past the defined ones, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_PROBE_MODE + 1'b1;

  // columns of the directed table
  localparam bit NO_CFG  = 1'b0;
  localparam bit NEW_CFG = 1'b1;
  localparam bit PREDICT = 1'b0;
  localparam bit GIVEN   = 1'b1;

  // one result transfer
  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [PROBE_W-1:0]   probes;
    logic [COUNT_W-1:0]   coll;
  } lookup_t;

  typedef struct packed {
    logic                 set_cfg;
    logic [TSIZE_W-1:0]   cfg_size;
    logic                 cfg_mode;
    logic                 kind;
    logic [KEY_W-1:0]     key;
    logic                 typed;
    status_t              exp_status;
    logic [SLOT_W-1:0]    exp_slot;
    logic [PROBE_W-1:0]   exp_probes;
    logic [COUNT_W-1:0]   exp_coll;
  } script_row_t;

  localparam int SCRIPT_LEN = 23;

  // directed stimulus: results typed in where they are obvious, else predicted
  script_row_t script_rows [SCRIPT_LEN] = '{
    // reset settings: 1024 slots, linear
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_SEARCH, 31'd0, GIVEN, ST_MISS, 10'd0, 11'd0, 32'd0},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_INSERT, 31'd0, GIVEN, ST_HOME, 10'd0, 11'd0, 32'd0},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_INSERT, 31'd1024, GIVEN, ST_COLL, 10'd1, 11'd1, 32'd1},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_SEARCH, 31'd1024, GIVEN, ST_FOUND, 10'd1, 11'd1, 32'd1},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_INSERT, KEY_MAX, GIVEN, ST_HOME, 10'd1023, 11'd0, 32'd1},
    // duplicate of the largest key wraps around the top slot
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_INSERT, KEY_MAX, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_SEARCH, KEY_MAX, GIVEN, ST_FOUND, 10'd1023, 11'd0, 32'd2},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_SEARCH, 31'd2048, PREDICT, ST_HOME, '0, '0, '0},
    // size zero acts as a single slot, already taken
    '{NEW_CFG, 11'd0, MODE_LINEAR, KIND_INSERT, 31'd5, GIVEN, ST_FULL, 10'd0, 11'd1, 32'd2},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_SEARCH, 31'd0, GIVEN, ST_FOUND, 10'd0, 11'd0, 32'd2},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_SEARCH, 31'd7, GIVEN, ST_MISS, 10'd0, 11'd1, 32'd2},
    '{NEW_CFG, 11'd1, MODE_QUADRATIC, KIND_INSERT, 31'd9, GIVEN, ST_FULL, 10'd0, 11'd1, 32'd2},
    // size above the ram depth saturates
    '{NEW_CFG, 11'd2047, MODE_QUADRATIC, KIND_INSERT, 31'd0, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_SEARCH, KEY_MAX, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_SEARCH, 31'd1024, PREDICT, ST_HOME, '0, '0, '0},
    // quadratic on 7 slots reaches only some residues, full with empties left
    '{NEW_CFG, 11'd7, MODE_QUADRATIC, KIND_INSERT, 31'd3, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_INSERT, 31'd3, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_INSERT, 31'd3, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_INSERT, 31'd3, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_SEARCH, 31'd3, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_QUADRATIC, KIND_SEARCH, 31'd10, PREDICT, ST_HOME, '0, '0, '0},
    '{NEW_CFG, 11'd1024, MODE_LINEAR, KIND_SEARCH, 31'd12345, PREDICT, ST_HOME, '0, '0, '0},
    '{NO_CFG, 11'd0, MODE_LINEAR, KIND_INSERT, 31'h4000_0000, PREDICT, ST_HOME, '0, '0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  kind;
  logic [KEY_W-1:0]      key;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot;
  logic [PROBE_W-1:0]    probes;
  logic [COUNT_W-1:0]    collision_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // mirror of the table and its registers
  bit                    slot_used [DEPTH];
  logic [KEY_W-1:0]      slot_keys [DEPTH];
  logic [COUNT_W-1:0]    coll_total;
  logic [TSIZE_W-1:0]    cur_size;
  logic                  cur_mode;

  lookup_t               pending_results [$];
  logic [KEY_W-1:0]      stored_keys [$];

  int     failures;
  int     mismatches;
  int     results_seen;
  int     items_sent;
  int     settings_used;
  int     status_seen [5];
  bit     calm;
  longint cycles;

  open_address_hash_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .key             (key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .slot            (slot),
    .probes          (probes),
    .collision_count (collision_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // slots in use: zero means one, anything past the ram depth is clipped
  function automatic int unsigned eff_size();
    if (cur_size == '0) return 1;
    if (32'(cur_size) > DEPTH) return DEPTH;
    return 32'(cur_size);
  endfunction

  // walk the probe sequence for one key, updating the mirror as the block does
  function automatic lookup_t probe_table(input logic op, input logic [KEY_W-1:0] kk);
    lookup_t          r;
    int unsigned      n;
    int unsigned      c;
    int unsigned      s;
    longint unsigned  cc;
    longint unsigned  off;
    n = eff_size();
    r.status = (op == KIND_INSERT) ? ST_FULL : ST_MISS;
    r.slot   = '0;
    r.probes = PROBE_W'(n);
    for (c = 0; c < n; c++) begin
      cc  = 64'(c);
      off = (cur_mode == MODE_QUADRATIC) ? cc * cc : cc;
      s   = 32'((64'(kk) + off) % 64'(n));
      if (op == KIND_INSERT) begin
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          slot_keys[s] = kk;
          r.slot       = SLOT_W'(s);
          r.probes     = PROBE_W'(c);
          if (c == 0) begin
            r.status = ST_HOME;
          end else begin
            r.status   = ST_COLL;
            coll_total = coll_total + 1'b1;
          end
          break;
        end
      end else begin
        // an empty slot ends the search
        if (!slot_used[s]) begin
          r.probes = PROBE_W'(c);
          break;
        end
        if (slot_keys[s] == kk) begin
          r.status = ST_FOUND;
          r.slot   = SLOT_W'(s);
          r.probes = PROBE_W'(c);
          break;
        end
      end
    end
    r.coll = coll_total;
    return r;
  endfunction

  // one register write, entered and left at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TABLE_SIZE) begin
      cur_size = val;
    end else if (idx == CFG_PROBE_MODE) begin
      cur_mode = val[0];
    end
    @(negedge clk);
  endtask

  // wait until the block is idle, then write both registers and a spare index
  task automatic set_table(input logic [TSIZE_W-1:0] size, input logic mode);
    logic [CFG_DATA_W-1:0] mode_word;
    logic [CFG_IDX_W-1:0]  spare_idx;
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // upper bits of the mode word are don't-care
    mode_word    = CFG_DATA_W'($urandom);
    mode_word[0] = mode;
    spare_idx    = CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, 2**CFG_IDX_W - 1));
    write_reg(CFG_TABLE_SIZE, size);
    write_reg(CFG_PROBE_MODE, mode_word);
    write_reg(spare_idx, CFG_DATA_W'($urandom));
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // offer one item, with random gaps; the expectation is queued on the transfer
  task automatic put_item(input logic op, input logic [KEY_W-1:0] kk, input bit use_given,
                          input lookup_t given);
    lookup_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind     = op;
    key      = kk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = probe_table(op, kk);
    pending_results.push_back(use_given ? given : r);
    items_sent++;
    @(negedge clk);
  endtask

  // result side: random stall, plus one long hold-off so the block backs up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (!held && results_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall = 1'b1;
      end else begin
        out_stall = !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (status <= ST_MISS) status_seen[status]++;
      if (pending_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result transfer with nothing pending (status %0d slot %0d)",
                   $time, status, slot);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || slot !== want.slot || probes !== want.probes ||
            collision_count !== want.coll) begin
          failures++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"%0t: mismatch got/exp status %0d/%0d slot %0d/%0d probes %0d/%0d",
                      " collisions %0d/%0d"}, $time, status, want.status, slot, want.slot,
                     probes, want.probes, collision_count, want.coll);
        end
      end
    end
  end

  // watchdog, sized well past the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int               ph;
    int               sel;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      s;
    logic             op;
    logic [KEY_W-1:0] kk;
    logic [KEY_W-1:0] base;
    lookup_t          given;
    int unsigned      open_slots [$];

    failures      = 0;
    mismatches    = 0;
    results_seen  = 0;
    items_sent    = 0;
    settings_used = 0;
    cycles        = 0;
    calm          = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KIND_INSERT;
    key       = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TABLE_SIZE;
    cfg_data  = '0;

    // mirror starts from the reset state: empty table, 1024 slots, linear
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    coll_total = '0;
    cur_size   = TSIZE_W'(DEPTH);
    cur_mode   = MODE_LINEAR;

    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed part; the block clears its ram first, the handshake covers that
    foreach (script_rows[i]) begin
      if (script_rows[i].set_cfg)
        set_table(script_rows[i].cfg_size, script_rows[i].cfg_mode);
      given = '{script_rows[i].exp_status, script_rows[i].exp_slot,
                script_rows[i].exp_probes, script_rows[i].exp_coll};
      put_item(script_rows[i].kind, script_rows[i].key, script_rows[i].typed, given);
    end

    // random phases: sizes grow so fresh slots keep opening up
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_table(TSIZE_W'($urandom_range(1 + 6 * ph, 24 + 28 * ph)),
                (ph == 0) ? MODE_LINEAR :
                (ph == 1) ? MODE_QUADRATIC : logic'($urandom_range(0, 1)));
      // one phase with no idling on either side
      calm = (ph == CALM_PHASE);
      n    = eff_size();
      repeat (PHASE_ITEMS) begin
        sel  = $urandom_range(0, 99);
        kk   = KEY_W'($urandom);
        base = (stored_keys.size() != 0) ?
               stored_keys[$urandom_range(0, stored_keys.size() - 1)] : kk;
        if (sel < 30) begin
          op = KIND_INSERT;
        end else if (sel < 42) begin
          // same home slot as an earlier key, forces a probe chain
          op = KIND_INSERT;
          kk = KEY_W'(64'(base) + 64'(n) * 64'($urandom_range(1, 4096)));
        end else if (sel < 48) begin
          op = KIND_INSERT;
          kk = base;
        end else if (sel < 85) begin
          op = KIND_SEARCH;
          kk = base;
        end else begin
          op = KIND_SEARCH;
        end
        if (op == KIND_INSERT) stored_keys.push_back(kk);
        put_item(op, kk, PREDICT, '0);
      end
    end
    calm = 1'b0;

    // fill every remaining slot with keys homed there, in random order
    set_table(TSIZE_W'(DEPTH), MODE_LINEAR);
    for (s = 0; s < DEPTH; s++)
      if (!slot_used[s]) open_slots.push_back(s);
    while (open_slots.size() != 0) begin
      pick = $urandom_range(0, open_slots.size() - 1);
      s    = open_slots[pick];
      open_slots.delete(pick);
      kk   = KEY_W'(64'(s) + 64'(DEPTH) * 64'($urandom_range(0, (1 << (KEY_W - SLOT_W)) - 1)));
      put_item(KIND_INSERT, kk, PREDICT, '0);
    end

    // full table: insert and search run through every slot
    put_item(KIND_INSERT, KEY_W'($urandom), PREDICT, '0);
    put_item(KIND_SEARCH, KEY_W'($urandom), PREDICT, '0);
    put_item(KIND_SEARCH, slot_keys[$urandom_range(0, DEPTH - 1)], PREDICT, '0);
    set_table({TSIZE_W{1'b1}}, MODE_QUADRATIC);
    put_item(KIND_SEARCH, slot_keys[$urandom_range(0, DEPTH - 1)], PREDICT, '0);
    put_item(KIND_INSERT, KEY_W'($urandom), PREDICT, '0);
    // shrink back to one slot, the rest stays stored but out of reach
    set_table('0, MODE_LINEAR);
    put_item(KIND_INSERT, KEY_W'($urandom), PREDICT, '0);
    put_item(KIND_SEARCH, slot_keys[0], PREDICT, '0);

    // let the last results drain, then watch for strays
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d items across %0d table settings (sizes 0 to 2047, linear and quadratic),",
             items_sent, settings_used);
    $display("results: %0d home, %0d after collision, %0d full, %0d found, %0d missing; %0d bad",
             status_seen[ST_HOME], status_seen[ST_COLL], status_seen[ST_FULL],
             status_seen[ST_FOUND], status_seen[ST_MISS], mismatches);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/oaht_pkg.sv
design/oaht_ram.sv
design/oaht_ctrl.sv
design/oaht_dp.sv
design/open_address_hash_table.sv
design/oaht_checker.sv
sim/open_address_hash_table_tb.sv
